// ----- rtl/gfsp_pkg.sv -----
// ----------------------------------------------------------------------------
// Gradient file stream parser package
// Shared types and codes for the gradient file stream parser.
// ----------------------------------------------------------------------------
package gfsp_pkg;

   // File constants.
   localparam logic [31:0] MAGIC_WORD    = 32'h3842_4752;
   localparam logic [15:0] MAJOR_VERSION = 16'd3;
   localparam logic [15:0] MIN_STOPS     = 16'd2;

   // Record kinds.
   localparam logic [2:0] KIND_HEADER  = 3'd0;
   localparam logic [2:0] KIND_TITLE   = 3'd1;
   localparam logic [2:0] KIND_COLOUR  = 3'd2;
   localparam logic [2:0] KIND_OPACITY = 3'd3;
   localparam logic [2:0] KIND_DONE    = 3'd4;
   localparam logic [2:0] KIND_ERROR   = 3'd5;

   // Error codes.
   localparam logic [3:0] ERR_MAGIC     = 4'd0;
   localparam logic [3:0] ERR_VERSION   = 4'd1;
   localparam logic [3:0] ERR_FEW_COL   = 4'd2;
   localparam logic [3:0] ERR_HEAD      = 4'd3;
   localparam logic [3:0] ERR_MIDPAD    = 4'd4;
   localparam logic [3:0] ERR_ZPAD      = 4'd5;
   localparam logic [3:0] ERR_RGBPAD    = 4'd6;
   localparam logic [3:0] ERR_BLOCKEND  = 4'd7;
   localparam logic [3:0] ERR_FEW_OPAC  = 4'd8;
   localparam logic [3:0] ERR_TRUNCATED = 4'd9;

   // Parser phases, one-hot.
   typedef enum logic [13:0] {
      PH_MAGIC  = 14'b00_0000_0000_0001,
      PH_VER    = 14'b00_0000_0000_0010,
      PH_TLEN   = 14'b00_0000_0000_0100,
      PH_TITLE  = 14'b00_0000_0000_1000,
      PH_RCOUNT = 14'b00_0000_0001_0000,
      PH_RHEAD  = 14'b00_0000_0010_0000,
      PH_RZ     = 14'b00_0000_0100_0000,
      PH_RMID   = 14'b00_0000_1000_0000,
      PH_RRGB   = 14'b00_0001_0000_0000,
      PH_BEND1  = 14'b00_0010_0000_0000,
      PH_OCOUNT = 14'b00_0100_0000_0000,
      PH_OSTOP  = 14'b00_1000_0000_0000,
      PH_BEND2  = 14'b01_0000_0000_0000,
      PH_DRAIN  = 14'b10_0000_0000_0000
   } phase_type;

   // One result record.
   typedef struct packed {
      logic [2:0]  rec_kind;
      logic [15:0] stop_index;
      logic [15:0] z_pos;
      logic [15:0] mid_point;
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic [15:0] opacity;
      logic [7:0]  title_byte;
      logic [15:0] version_minor;
      logic [3:0]  error_code;
      logic        unusual;
   } record_type;

endpackage

// ----- rtl/gradient_file_stream_parser.sv -----
// ----------------------------------------------------------------------------
// Gradient file stream parser
// Parses a gradient file one byte per transfer and emits header, title,
// colour stop, opacity stop, done and error records.
// ----------------------------------------------------------------------------
// Output: a record is registered and appears on the rsp channel in the cycle
// after the byte that completes it is transferred in.
// Throughput: one byte per cycle unless a record waits on rsp_ready; the single
// result register takes a new record in the same cycle the previous one leaves.
// Reset: synchronous, active high; the parser waits for the magic of a file.
module gradient_file_stream_parser import gfsp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_stream,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_rec_kind,
   output logic [15:0] rsp_stop_index,
   output logic [15:0] rsp_z_pos,
   output logic [15:0] rsp_mid_point,
   output logic [15:0] rsp_red,
   output logic [15:0] rsp_green,
   output logic [15:0] rsp_blue,
   output logic [15:0] rsp_opacity,
   output logic [7:0]  rsp_title_byte,
   output logic [15:0] rsp_version_minor,
   output logic [3:0]  rsp_error_code,
   output logic        rsp_unusual
);

   // Parser state.
   phase_type   phase_ff, phase_in;
   logic [3:0]  byte_pos_ff, byte_pos_in;
   logic [31:0] word_shift_ff, word_shift_in;
   logic [15:0] remaining_ff, remaining_in;
   logic [15:0] stop_counter_ff, stop_counter_in;
   logic [15:0] held_z_ff, held_z_in;
   logic [15:0] held_mid_ff, held_mid_in;
   logic [15:0] held_red_ff, held_red_in;
   logic [15:0] held_green_ff, held_green_in;
   logic        pad_flag_ff, pad_flag_in;

   // Result register.
   record_type  rsp_rec_ff, rsp_rec_in;
   logic        rsp_valid_ff;
   logic        emit;
   logic        req_fire;

   // A byte is taken whenever the result register is empty or being emptied.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   // Decode one byte against the current phase.
   always_comb begin
      logic [31:0] shift_new;
      logic [15:0] hi;
      logic [15:0] lo;
      logic [3:0]  pos;
      logic [15:0] rem_dec;

      phase_in        = phase_ff;
      byte_pos_in     = byte_pos_ff;
      word_shift_in   = word_shift_ff;
      remaining_in    = remaining_ff;
      stop_counter_in = stop_counter_ff;
      held_z_in       = held_z_ff;
      held_mid_in     = held_mid_ff;
      held_red_in     = held_red_ff;
      held_green_in   = held_green_ff;
      pad_flag_in     = pad_flag_ff;
      rsp_rec_in      = '0;
      emit            = 1'b0;

      shift_new = {word_shift_ff[23:0], req_data_byte};
      hi        = shift_new[31:16];
      lo        = shift_new[15:0];
      pos       = byte_pos_ff;
      rem_dec   = remaining_ff - 16'd1;

      if (req_end_of_stream) begin
         // End of stream: quiet between files, truncation inside one.
         phase_in    = PH_MAGIC;
         byte_pos_in = '0;
         if (!(phase_ff == PH_DRAIN || (phase_ff == PH_MAGIC && byte_pos_ff == 4'd0))) begin
            emit                  = 1'b1;
            rsp_rec_in.rec_kind   = KIND_ERROR;
            rsp_rec_in.error_code = ERR_TRUNCATED;
         end
      end else if (phase_ff != PH_DRAIN) begin
         word_shift_in = shift_new;
         byte_pos_in   = pos + 4'd1;

         case (phase_ff)
            PH_MAGIC: begin
               if (pos >= 4'd3) begin
                  byte_pos_in = '0;
                  if (shift_new != MAGIC_WORD) begin
                     emit                  = 1'b1;
                     rsp_rec_in.rec_kind   = KIND_ERROR;
                     rsp_rec_in.error_code = ERR_MAGIC;
                     phase_in              = PH_DRAIN;
                  end else begin
                     phase_in = PH_VER;
                  end
               end
            end
            PH_VER: begin
               if (pos >= 4'd3) begin
                  byte_pos_in = '0;
                  emit        = 1'b1;
                  if (hi != MAJOR_VERSION) begin
                     rsp_rec_in.rec_kind   = KIND_ERROR;
                     rsp_rec_in.error_code = ERR_VERSION;
                     phase_in              = PH_DRAIN;
                  end else begin
                     rsp_rec_in.rec_kind      = KIND_HEADER;
                     rsp_rec_in.version_minor = lo;
                     phase_in                 = PH_TLEN;
                  end
               end
            end
            PH_TLEN: begin
               // An empty title goes straight on to the colour stop count.
               remaining_in = {8'd0, req_data_byte};
               byte_pos_in  = '0;
               phase_in     = (req_data_byte == 8'd0) ? PH_RCOUNT : PH_TITLE;
            end
            PH_TITLE: begin
               remaining_in          = rem_dec;
               emit                  = 1'b1;
               rsp_rec_in.rec_kind   = KIND_TITLE;
               rsp_rec_in.title_byte = req_data_byte;
               if (rem_dec == 16'd0) begin
                  byte_pos_in = '0;
                  phase_in    = PH_RCOUNT;
               end
            end
            PH_RCOUNT: begin
               if (pos >= 4'd1) begin
                  byte_pos_in = '0;
                  if (lo < MIN_STOPS) begin
                     emit                  = 1'b1;
                     rsp_rec_in.rec_kind   = KIND_ERROR;
                     rsp_rec_in.error_code = ERR_FEW_COL;
                     phase_in              = PH_DRAIN;
                  end else begin
                     remaining_in    = lo;
                     stop_counter_in = '0;
                     phase_in        = PH_RHEAD;
                  end
               end
            end
            PH_RHEAD: begin
               // Only the first head word is checked; the first stop has no z.
               if (pos >= 4'd3) begin
                  byte_pos_in = '0;
                  if (hi != 16'd0) begin
                     emit                  = 1'b1;
                     rsp_rec_in.rec_kind   = KIND_ERROR;
                     rsp_rec_in.error_code = ERR_HEAD;
                     phase_in              = PH_DRAIN;
                  end else if (stop_counter_ff == 16'd0) begin
                     held_z_in = '0;
                     phase_in  = PH_RMID;
                  end else begin
                     phase_in = PH_RZ;
                  end
               end
            end
            PH_RZ: begin
               if (pos >= 4'd3) begin
                  byte_pos_in = '0;
                  if (hi != 16'd0) begin
                     emit                  = 1'b1;
                     rsp_rec_in.rec_kind   = KIND_ERROR;
                     rsp_rec_in.error_code = ERR_ZPAD;
                     phase_in              = PH_DRAIN;
                  end else begin
                     held_z_in = lo;
                     phase_in  = PH_RMID;
                  end
               end
            end
            PH_RMID: begin
               if (pos >= 4'd3) begin
                  byte_pos_in = '0;
                  if (hi != 16'd0) begin
                     emit                  = 1'b1;
                     rsp_rec_in.rec_kind   = KIND_ERROR;
                     rsp_rec_in.error_code = ERR_MIDPAD;
                     phase_in              = PH_DRAIN;
                  end else begin
                     held_mid_in = lo;
                     pad_flag_in = 1'b0;
                     phase_in    = PH_RRGB;
                  end
               end
            end
            PH_RRGB: begin
               // The pad before red is only reported once blue has arrived.
               if (pos == 4'd3) begin
                  pad_flag_in = (hi != 16'd0);
                  held_red_in = lo;
               end else if (pos == 4'd5) begin
                  held_green_in = lo;
               end else if (pos >= 4'd7) begin
                  byte_pos_in = '0;
                  emit        = 1'b1;
                  if (pad_flag_ff) begin
                     rsp_rec_in.rec_kind   = KIND_ERROR;
                     rsp_rec_in.error_code = ERR_RGBPAD;
                     phase_in              = PH_DRAIN;
                  end else begin
                     rsp_rec_in.rec_kind   = KIND_COLOUR;
                     rsp_rec_in.stop_index = stop_counter_ff;
                     rsp_rec_in.z_pos      = held_z_ff;
                     rsp_rec_in.mid_point  = held_mid_ff;
                     rsp_rec_in.red        = held_red_ff;
                     rsp_rec_in.green      = held_green_ff;
                     rsp_rec_in.blue       = lo;
                     stop_counter_in       = stop_counter_ff + 16'd1;
                     remaining_in          = rem_dec;
                     phase_in              = (rem_dec == 16'd0) ? PH_BEND1 : PH_RHEAD;
                  end
               end
            end
            PH_BEND1, PH_BEND2: begin
               if (pos >= 4'd3) begin
                  byte_pos_in = '0;
                  if (shift_new != 32'd0) begin
                     emit                  = 1'b1;
                     rsp_rec_in.rec_kind   = KIND_ERROR;
                     rsp_rec_in.error_code = ERR_BLOCKEND;
                     phase_in              = PH_DRAIN;
                  end else if (phase_ff == PH_BEND1) begin
                     phase_in = PH_OCOUNT;
                  end else begin
                     emit                = 1'b1;
                     rsp_rec_in.rec_kind = KIND_DONE;
                     phase_in            = PH_MAGIC;
                  end
               end
            end
            PH_OCOUNT: begin
               if (pos >= 4'd1) begin
                  byte_pos_in = '0;
                  if (lo < MIN_STOPS) begin
                     emit                  = 1'b1;
                     rsp_rec_in.rec_kind   = KIND_ERROR;
                     rsp_rec_in.error_code = ERR_FEW_OPAC;
                     phase_in              = PH_DRAIN;
                  end else begin
                     remaining_in    = lo;
                     stop_counter_in = '0;
                     pad_flag_in     = 1'b0;
                     phase_in        = PH_OSTOP;
                  end
               end
            end
            PH_OSTOP: begin
               // Nonzero pad words only raise the unusual flag.
               if (pos == 4'd1 || pos == 4'd5) begin
                  if (lo != 16'd0) begin
                     pad_flag_in = 1'b1;
                  end
               end else if (pos == 4'd3) begin
                  held_z_in = lo;
               end else if (pos == 4'd7) begin
                  held_mid_in = lo;
               end else if (pos >= 4'd9) begin
                  byte_pos_in           = '0;
                  emit                  = 1'b1;
                  rsp_rec_in.rec_kind   = KIND_OPACITY;
                  rsp_rec_in.stop_index = stop_counter_ff;
                  rsp_rec_in.z_pos      = held_z_ff;
                  rsp_rec_in.mid_point  = held_mid_ff;
                  rsp_rec_in.opacity    = lo;
                  rsp_rec_in.unusual    = pad_flag_ff;
                  pad_flag_in           = 1'b0;
                  stop_counter_in       = stop_counter_ff + 16'd1;
                  remaining_in          = rem_dec;
                  phase_in              = (rem_dec == 16'd0) ? PH_BEND2 : PH_OSTOP;
               end
            end
            default: begin
               byte_pos_in = '0;
               phase_in    = PH_DRAIN;
            end
         endcase
      end
   end

   // State and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_MAGIC;
         byte_pos_ff     <= '0;
         word_shift_ff   <= '0;
         remaining_ff    <= '0;
         stop_counter_ff <= '0;
         held_z_ff       <= '0;
         held_mid_ff     <= '0;
         held_red_ff     <= '0;
         held_green_ff   <= '0;
         pad_flag_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else if (req_fire) begin
         phase_ff        <= phase_in;
         byte_pos_ff     <= byte_pos_in;
         word_shift_ff   <= word_shift_in;
         remaining_ff    <= remaining_in;
         stop_counter_ff <= stop_counter_in;
         held_z_ff       <= held_z_in;
         held_mid_ff     <= held_mid_in;
         held_red_ff     <= held_red_in;
         held_green_ff   <= held_green_in;
         pad_flag_ff     <= pad_flag_in;
         rsp_valid_ff    <= emit;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload needs no reset.
   always_ff @(posedge clock) begin
      if (req_fire && emit) begin
         rsp_rec_ff <= rsp_rec_in;
      end
   end

   // Output ports.
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_rec_kind      = rsp_rec_ff.rec_kind;
   assign rsp_stop_index    = rsp_rec_ff.stop_index;
   assign rsp_z_pos         = rsp_rec_ff.z_pos;
   assign rsp_mid_point     = rsp_rec_ff.mid_point;
   assign rsp_red           = rsp_rec_ff.red;
   assign rsp_green         = rsp_rec_ff.green;
   assign rsp_blue          = rsp_rec_ff.blue;
   assign rsp_opacity       = rsp_rec_ff.opacity;
   assign rsp_title_byte    = rsp_rec_ff.title_byte;
   assign rsp_version_minor = rsp_rec_ff.version_minor;
   assign rsp_error_code    = rsp_rec_ff.error_code;
   assign rsp_unusual       = rsp_rec_ff.unusual;

endmodule
